// ===== sv/tgi_pkg.sv =====
// ----------------------------------------------------------------------------
// tgi_pkg
// Shared types, constants and helpers for the trilinear grid interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package tgi_pkg;

    localparam int DEF_MAX_SLICES  = 64;
    localparam int DEF_GRID_SIDE   = 128;
    localparam int DEF_FIELD_COUNT = 3;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_START_TIME     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_TIME_STEP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_CELL_SIZE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_START_TIME = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_PER_SIDE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_SLICES    = 3'd6;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] FLD_TEMP = 2'd0;
    localparam logic [1:0] FLD_VX   = 2'd1;
    localparam logic [1:0] FLD_VY   = 2'd2;

    typedef struct packed {
        logic        op;
        logic [1:0]  field_sel;
        logic [5:0]  slice_index;
        logic [6:0]  row_index;
        logic [6:0]  col_index;
        logic [31:0] load_value;
        logic [31:0] query_time;
        logic [31:0] query_x;
        logic [31:0] query_y;
    } tgi_in_t;

    typedef struct packed {
        logic [31:0] result_value;
        logic        in_grid;
        logic        early_time;
    } tgi_out_t;

    // a + floor(((b - a) * f + 2^15) / 2^16); result fits in 32 bits
    function automatic logic signed [31:0] lerp16(input logic signed [31:0] a,
                                                  input logic signed [31:0] b,
                                                  input logic [15:0] f);
        logic signed [32:0] d;
        logic signed [50:0] p;
        logic signed [34:0] s;
        begin
            d = 33'(b) - 33'(a);
            p = 51'(d) * $signed({35'd0, f}) + 51'sd32768;
            s = 35'(a) + 35'(p >>> 16);
            lerp16 = s[31:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== sv/tgi_stream_if.sv =====
// ----------------------------------------------------------------------------
// tgi_stream_if
// Valid/ready channel carrying one payload of type T.
// ----------------------------------------------------------------------------
`default_nettype none

interface tgi_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/trilinear_grid_interpolator.sv =====
// ----------------------------------------------------------------------------
// trilinear_grid_interpolator
// Gridded field store with trilinear interpolation queries.
// ----------------------------------------------------------------------------
// channel | dir | payload                               | handshake
// in_ch   | in  | op, field_sel, indexes, value, t, x, y | valid/ready
// out_ch  | out | result_value, in_grid, early_time    | valid/ready
// cfg     | in  | cfg_we, cfg_index, cfg_wdata           | write enable only
//
// A load is one memory write and leaves the block in idle, so loads go back
// to back. A query inside the grid runs the setup states (coordinate
// multiplies, range check), the read state (8 corner reads from the
// single-port grid RAM, then draining the read pipe), the blend states
// (blending and early scaling) and the output state that loads the output
// register; the next item is taken once the block is back in idle. A query
// outside the grid skips the reads and the blend states.
// Output is one register; the next item is accepted while a result waits, and
// a following query holds in its output state until that register empties.
// Reset clears control state only; the grid RAM has no clearing pass.
`default_nettype none

module trilinear_grid_interpolator
    import tgi_pkg::*;
#(
    parameter int MAX_SLICES  = DEF_MAX_SLICES,
    parameter int GRID_SIDE   = DEF_GRID_SIDE,
    parameter int FIELD_COUNT = DEF_FIELD_COUNT
) (
    input  wire                    clk,
    input  wire                    rst_n,
    tgi_stream_if.sink             in_ch,
    tgi_stream_if.source           out_ch,
    input  wire                    cfg_we,
    input  wire  [CFG_IDX_W-1:0]   cfg_index,
    input  wire  [CFG_DATA_W-1:0]  cfg_wdata
);
    localparam int SW    = $clog2(MAX_SLICES);
    localparam int GW    = $clog2(GRID_SIDE);
    localparam int FW    = (FIELD_COUNT > 1) ? $clog2(FIELD_COUNT) : 1;
    localparam int DEPTH = FIELD_COUNT * MAX_SLICES * GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MUL   = 6'b000010,
        ST_CHK   = 6'b000100,
        ST_READ  = 6'b001000,
        ST_BLEND = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    // configuration
    logic [31:0] start_time_reg, inv_time_step_reg, half_width_reg;
    logic [31:0] inv_cell_size_reg, inv_start_time_reg;
    logic [7:0]  cells_per_side_reg;
    logic [6:0]  time_slices_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_time_reg     <= 32'd26214;
            inv_time_step_reg  <= 32'd655360;
            half_width_reg     <= 32'd838861;
            inv_cell_size_reg  <= 32'd327680;
            inv_start_time_reg <= 32'd163840;
            cells_per_side_reg <= 8'd128;
            time_slices_reg    <= 7'd64;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_START_TIME:     start_time_reg     <= cfg_wdata;
                REG_INV_TIME_STEP:  inv_time_step_reg  <= cfg_wdata;
                REG_HALF_WIDTH:     half_width_reg     <= cfg_wdata;
                REG_INV_CELL_SIZE:  inv_cell_size_reg  <= cfg_wdata;
                REG_INV_START_TIME: inv_start_time_reg <= cfg_wdata;
                REG_CELLS_PER_SIDE: cells_per_side_reg <= cfg_wdata[7:0];
                REG_TIME_SLICES:    time_slices_reg    <= cfg_wdata[6:0];
                default:            ;
            endcase
        end
    end

    state_t      state_reg;
    logic [1:0]  fld_reg;
    logic        early_reg, inside_reg, scale_reg;
    logic signed [31:0] t_reg;
    logic [33:0] dt_reg, px_reg, py_reg;
    logic [49:0] tc_reg, xc_reg, yc_reg;
    logic [3:0]  rd_cnt_reg;
    logic        rd_pend_reg;
    logic [2:0]  rd_tag_reg;
    logic signed [31:0] corner_reg [8];
    logic [2:0]  blend_cnt_reg;
    logic signed [31:0] lv_reg [4];
    logic signed [32:0] ratio_reg;
    logic signed [31:0] val_reg;
    logic        out_valid_reg;
    tgi_out_t    out_data_reg;

    wire accept = in_ch.valid && in_ch.ready;
    wire is_load = in_ch.data.op == OP_LOAD;

    // a load writes straight to the RAM; any item is taken only from idle
    assign in_ch.ready = (state_reg == ST_IDLE);

    // ---- index / fraction decode
    logic [33:0] it_w, ix_w, iy_w;
    assign it_w = tc_reg[49:16];
    assign ix_w = xc_reg[49:16];
    assign iy_w = yc_reg[49:16];

    logic [8:0] nside_w;
    logic [8:0] nslice_w;
    assign nside_w  = (9'(cells_per_side_reg) > 9'(GRID_SIDE)) ? 9'(GRID_SIDE)
                                                               : 9'(cells_per_side_reg);
    assign nslice_w = (9'(time_slices_reg) > 9'(MAX_SLICES)) ? 9'(MAX_SLICES)
                                                             : 9'(time_slices_reg);

    // corner address: tag bits [2]=time, [1]=row, [0]=col
    logic [AW-1:0] q_addr;
    always_comb
    begin
        logic [SW-1:0] s;
        logic [GW-1:0] r, c;
        s = SW'(it_w) + SW'(rd_cnt_reg[2]);
        r = GW'(iy_w) + GW'(rd_cnt_reg[1]);
        c = GW'(ix_w) + GW'(rd_cnt_reg[0]);
        q_addr = AW'((((FW'(fld_reg) * (AW+1)'(MAX_SLICES) + s) * GRID_SIDE + r)
                      * GRID_SIDE) + c);
    end

    logic [AW-1:0] l_addr;
    assign l_addr = AW'((((FW'(in_ch.data.field_sel) * (AW+1)'(MAX_SLICES)
                       + SW'(in_ch.data.slice_index)) * GRID_SIDE
                       + GW'(in_ch.data.row_index)) * GRID_SIDE)
                       + GW'(in_ch.data.col_index));

    wire load_ok = (32'(in_ch.data.field_sel) < 32'(FIELD_COUNT))
                && (32'(in_ch.data.slice_index) < 32'(MAX_SLICES))
                && (32'(in_ch.data.row_index) < 32'(GRID_SIDE))
                && (32'(in_ch.data.col_index) < 32'(GRID_SIDE));
    wire ram_we = accept && is_load && load_ok;
    wire ram_re = (state_reg == ST_READ) && !rd_cnt_reg[3];
    logic [31:0] ram_rdata;

    tgi_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_we ? l_addr : q_addr),
        .wdata (in_ch.data.load_value),
        .rdata (ram_rdata)
    );

    // ---- blend sequencer
    logic signed [31:0] blend_w;
    always_comb
    begin
        unique case (blend_cnt_reg)
            3'd0:    blend_w = lerp16(corner_reg[0], corner_reg[1], xc_reg[15:0]);
            default: blend_w = 32'sd0;
        endcase
    end

    logic signed [64:0] sprod_w;
    assign sprod_w = 65'(val_reg) * 65'(ratio_reg);
    logic signed [48:0] sshift_w;
    assign sshift_w = 49'(sprod_w >>> 16);

    logic signed [64:0] rprod_w;
    assign rprod_w = 65'(t_reg) * $signed({33'd0, inv_start_time_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            rd_cnt_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            blend_cnt_reg <= '0;
        end
        else
        begin
            // in the output state the register is reloaded below instead
            if (out_ch.valid && out_ch.ready && state_reg != ST_OUT)
            begin
                out_valid_reg <= 1'b0;
            end
            rd_pend_reg <= ram_re;
            rd_tag_reg  <= rd_cnt_reg[2:0];
            if (rd_pend_reg)
            begin
                corner_reg[rd_tag_reg] <= $signed(ram_rdata);
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && !is_load)
                    begin
                        logic signed [32:0] t33, st33, et33;
                        t33  = 33'($signed(in_ch.data.query_time));
                        st33 = $signed({1'b0, start_time_reg});
                        et33 = (t33 < st33) ? st33 : t33;
                        t_reg     <= $signed(in_ch.data.query_time);
                        early_reg <= t33 < st33;
                        fld_reg   <= in_ch.data.field_sel;
                        dt_reg    <= 34'(et33 - st33);
                        px_reg    <= 34'($signed(in_ch.data.query_x))
                                     + $signed({2'b0, half_width_reg});
                        py_reg    <= 34'($signed(in_ch.data.query_y))
                                     + $signed({2'b0, half_width_reg});
                        inside_reg <= 32'(in_ch.data.field_sel) < 32'(FIELD_COUNT);
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    // px, py are 34-bit signed sums; bit 33 flags negative
                    if (px_reg[33] || py_reg[33])
                    begin
                        inside_reg <= 1'b0;
                    end
                    tc_reg <= 50'((66'(dt_reg) * 66'(inv_time_step_reg)) >> 16);
                    xc_reg <= 50'((66'(px_reg) * 66'(inv_cell_size_reg)) >> 16);
                    yc_reg <= 50'((66'(py_reg) * 66'(inv_cell_size_reg)) >> 16);
                    ratio_reg <= 33'(rprod_w >>> 16);
                    state_reg <= ST_CHK;
                end
                ST_CHK:
                begin
                    if (ratio_reg > 33'sh0_8000_0000 || rprod_w[64:47] != {18{rprod_w[64]}})
                    begin
                        ratio_reg <= rprod_w[64] ? -33'sh0_8000_0000 : 33'sh0_8000_0000;
                    end
                    if (!inside_reg || (35'(it_w) + 35'd1 >= 35'(nslice_w))
                        || (35'(ix_w) + 35'd1 >= 35'(nside_w))
                        || (35'(iy_w) + 35'd1 >= 35'(nside_w)))
                    begin
                        inside_reg <= 1'b0;
                        val_reg    <= 32'sd0;
                        state_reg  <= ST_OUT;
                    end
                    else
                    begin
                        rd_cnt_reg <= '0;
                        state_reg  <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    if (!rd_cnt_reg[3])
                    begin
                        rd_cnt_reg <= rd_cnt_reg + 4'd1;
                    end
                    else if (!rd_pend_reg)
                    begin
                        blend_cnt_reg <= '0;
                        state_reg     <= ST_BLEND;
                    end
                end
                ST_BLEND:
                begin
                    blend_cnt_reg <= blend_cnt_reg + 3'd1;
                    unique case (blend_cnt_reg)
                        3'd0:
                        begin
                            lv_reg[0] <= blend_w;
                            lv_reg[1] <= lerp16(corner_reg[2], corner_reg[3], xc_reg[15:0]);
                            lv_reg[2] <= lerp16(corner_reg[4], corner_reg[5], xc_reg[15:0]);
                            lv_reg[3] <= lerp16(corner_reg[6], corner_reg[7], xc_reg[15:0]);
                        end
                        3'd1:
                        begin
                            lv_reg[0] <= lerp16(lv_reg[0], lv_reg[1], yc_reg[15:0]);
                            lv_reg[2] <= lerp16(lv_reg[2], lv_reg[3], yc_reg[15:0]);
                        end
                        3'd2:
                        begin
                            val_reg <= lerp16(lv_reg[0], lv_reg[2], tc_reg[15:0]);
                            scale_reg <= early_reg && (fld_reg == FLD_VX || fld_reg == FLD_VY);
                        end
                        default:
                        begin
                            if (scale_reg)
                            begin
                                if (sshift_w > 49'sh0_7FFF_FFFF)
                                    val_reg <= 32'sh7FFF_FFFF;
                                else if (sshift_w < -49'sh0_8000_0000)
                                    val_reg <= 32'sh8000_0000;
                                else
                                    val_reg <= sshift_w[31:0];
                            end
                            state_reg <= ST_OUT;
                        end
                    endcase
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || out_ch.ready)
                    begin
                        out_valid_reg             <= 1'b1;
                        out_data_reg.result_value <= val_reg;
                        out_data_reg.in_grid      <= inside_reg;
                        out_data_reg.early_time   <= early_reg;
                        state_reg                 <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> state_reg == ST_IDLE)
        else $error("ready outside idle");
    a_no_read_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("RAM read and write collide");
    a_zero_outside: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.data.in_grid |-> out_ch.data.result_value == 32'd0)
        else $error("nonzero result outside grid");
    a_read_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_BLEND |-> rd_cnt_reg == 4'd8)
        else $error("blend before all corners read");
endmodule

`default_nettype wire

// ===== sv/tgi_ram.sv =====
// ----------------------------------------------------------------------------
// tgi_ram
// Generic single-port RAM, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tgi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire                      re,
    input  wire  [$clog2(DEPTH)-1:0] addr,
    input  wire  [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else if (re)
        begin
            rdata <= mem[addr];
        end
    end
endmodule

`default_nettype wire

// ===== test/tb_trilinear_grid_interpolator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_trilinear_grid_interpolator
// Loads a small grid region for all three fields, then drives directed and
// random queries and loads over several register settings. A behavioral
// blend of the eight corners predicts every result, checked field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_trilinear_grid_interpolator;
    import tgi_pkg::*;

    localparam int  FILL_SLICES = 4;
    localparam int  FILL_SIDE   = 6;
    localparam int  STALL_LIMIT = 5000;
    localparam real CLK_PERIOD  = 10.0;

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    tgi_stream_if #(.T(tgi_in_t))  in_ch ();
    tgi_stream_if #(.T(tgi_out_t)) out_ch ();

    trilinear_grid_interpolator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // register mirror
    logic [31:0] start_t, inv_step, half_w, inv_cell, inv_start;
    logic [7:0]  side_cnt;
    logic [6:0]  slice_cnt;

    logic [31:0] grid_mem [int];
    tgi_out_t    pending_results [$];
    int          mismatches = 0;
    bit          idle_on = 1'b1;
    int          hold_cycles = 0;
    int          quiet_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic int grid_key(int fld, longint s, longint r, longint c);
        return int'(((fld * DEF_MAX_SLICES + s) * DEF_GRID_SIDE + r) * DEF_GRID_SIDE + c);
    endfunction

    function automatic logic [63:0] cell_coord(logic [63:0] v, logic [31:0] inv);
        logic [63:0] inv64;
        begin
            inv64 = {32'd0, inv};
            return (v >> 16) * inv64 + (((v & 64'hFFFF) * inv64) >> 16);
        end
    endfunction

    function automatic longint blend(longint a, longint b, logic [15:0] f);
        return a + (((b - a) * longint'({48'd0, f}) + 32768) >>> 16);
    endfunction

    // returns 0 when the query would read a grid word never written
    function automatic bit predict_query(tgi_in_t it, output tgi_out_t r);
        longint      t, et, px, py, val, ratio;
        logic [63:0] tc, xc, yc, ti, xi, yi, nside, nslice;
        logic [15:0] ft, fx, fy;
        longint      c [8];
        bit          early, hit;
        int          fld, k;
        begin
            fld = it.field_sel;
            t = longint'($signed(it.query_time));
            early = t < longint'({32'd0, start_t});
            et = early ? longint'({32'd0, start_t}) : t;
            nside = side_cnt > DEF_GRID_SIDE ? DEF_GRID_SIDE : side_cnt;
            nslice = slice_cnt > DEF_MAX_SLICES ? DEF_MAX_SLICES : slice_cnt;
            px = longint'($signed(it.query_x)) + longint'({32'd0, half_w});
            py = longint'($signed(it.query_y)) + longint'({32'd0, half_w});
            val = 0;
            hit = fld < DEF_FIELD_COUNT && px >= 0 && py >= 0;
            if (hit)
            begin
                tc = cell_coord(64'(et - longint'({32'd0, start_t})), inv_step);
                xc = cell_coord(64'(px), inv_cell);
                yc = cell_coord(64'(py), inv_cell);
                ti = tc >> 16;
                xi = xc >> 16;
                yi = yc >> 16;
                ft = tc[15:0];
                fx = xc[15:0];
                fy = yc[15:0];
                if (ti + 1 >= nslice || xi + 1 >= nside || yi + 1 >= nside)
                    hit = 1'b0;
            end
            if (hit)
            begin
                // corner order: bit0 x, bit1 y, bit2 time
                for (k = 0; k < 8; k++)
                begin
                    if (!grid_mem.exists(grid_key(fld, ti + k[2], yi + k[1], xi + k[0])))
                        return 1'b0;
                    c[k] = longint'($signed(grid_mem[grid_key(fld, ti + k[2], yi + k[1],
                                                              xi + k[0])]));
                end
                val = blend(blend(blend(c[0], c[1], fx), blend(c[2], c[3], fx), fy),
                            blend(blend(c[4], c[5], fx), blend(c[6], c[7], fx), fy), ft);
                if (early && (it.field_sel == FLD_VX || it.field_sel == FLD_VY))
                begin
                    ratio = (t * longint'({32'd0, inv_start})) >>> 16;
                    if (ratio > (longint'(1) << 31))
                        ratio = longint'(1) << 31;
                    if (ratio < -(longint'(1) << 31))
                        ratio = -(longint'(1) << 31);
                    val = (val * ratio) >>> 16;
                    if (val > 64'sh7FFFFFFF)
                        val = 64'sh7FFFFFFF;
                    if (val < -64'sh80000000)
                        val = -64'sh80000000;
                end
            end
            r.result_value = val[31:0];
            r.in_grid = hit;
            r.early_time = early;
            return 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic send_item(tgi_in_t it);
        tgi_out_t r;
        begin
            if (it.op == OP_QUERY)
                void'(predict_query(it, r));
            if (idle_on && $urandom_range(0, 3) == 0)
            begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            in_ch.data <= it;
            in_ch.valid <= 1'b1;
            @(posedge clk);
            while (!in_ch.ready)
                @(posedge clk);
            if (it.op == OP_QUERY)
                pending_results.push_back(r);
            else if (it.field_sel < DEF_FIELD_COUNT)
                grid_mem[grid_key(it.field_sel, it.slice_index, it.row_index,
                                  it.col_index)] = it.load_value;
        end
    endtask

    task automatic drain();
        begin
            in_ch.valid <= 1'b0;
            while (pending_results.size() != 0)
                @(posedge clk);
            repeat (20) @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] wdata);
        begin
            cfg_we <= 1'b1;
            cfg_index <= idx;
            cfg_wdata <= wdata;
            @(posedge clk);
            cfg_we <= 1'b0;
            case (idx)
                REG_START_TIME:     start_t = wdata;
                REG_INV_TIME_STEP:  inv_step = wdata;
                REG_HALF_WIDTH:     half_w = wdata;
                REG_INV_CELL_SIZE:  inv_cell = wdata;
                REG_INV_START_TIME: inv_start = wdata;
                REG_CELLS_PER_SIDE: side_cnt = wdata[7:0];
                REG_TIME_SLICES:    slice_cnt = wdata[6:0];
                default: ;
            endcase
        end
    endtask

    task automatic set_config(logic [31:0] st, logic [31:0] stp, logic [31:0] hw,
                              logic [31:0] cl, logic [31:0] ist, logic [7:0] sides,
                              logic [6:0] slices);
        begin
            drain();
            write_reg(REG_START_TIME, st);
            write_reg(REG_INV_TIME_STEP, stp);
            write_reg(REG_HALF_WIDTH, hw);
            write_reg(REG_INV_CELL_SIZE, cl);
            write_reg(REG_INV_START_TIME, ist);
            write_reg(REG_CELLS_PER_SIDE, {24'd0, sides});
            write_reg(REG_TIME_SLICES, {25'd0, slices});
        end
    endtask

    // ------------------------------------------------------------------
    // item builders
    // ------------------------------------------------------------------
    function automatic tgi_in_t query_item(logic [1:0] fld, logic [31:0] t,
                                           logic [31:0] x, logic [31:0] y);
        tgi_in_t it;
        begin
            it = tgi_in_t'($bits(tgi_in_t)'({$urandom, $urandom, $urandom, $urandom,
                                              $urandom, $urandom}));
            it.op = OP_QUERY;
            it.field_sel = fld;
            it.query_time = t;
            it.query_x = x;
            it.query_y = y;
            return it;
        end
    endfunction

    function automatic tgi_in_t load_item(logic [1:0] fld, logic [5:0] s, logic [6:0] r,
                                          logic [6:0] c, logic [31:0] v);
        tgi_in_t it;
        begin
            it = tgi_in_t'($bits(tgi_in_t)'({$urandom, $urandom, $urandom, $urandom,
                                              $urandom, $urandom}));
            it.op = OP_LOAD;
            it.field_sel = fld;
            it.slice_index = s;
            it.row_index = r;
            it.col_index = c;
            it.load_value = v;
            return it;
        end
    endfunction

    // position that lands near cell coordinate 0..span, clamped to int32
    function automatic logic [31:0] aim(logic [31:0] inv, longint base, int span);
        longint cc, p;
        begin
            if (inv == 0)
                return $urandom;
            cc = longint'($urandom_range(0, span * 65536 + 65535));
            p = (cc << 16) / longint'({32'd0, inv}) + base;
            if (p > 64'sh7FFFFFFF)
                p = 64'sh7FFFFFFF;
            if (p < -64'sh80000000)
                p = -64'sh80000000;
            return p[31:0];
        end
    endfunction

    function automatic logic [31:0] rand_grid_value();
        case ($urandom_range(0, 5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom_range(0, 1 << 25) - (1 << 24);
            default: return $urandom;
        endcase
    endfunction

    function automatic tgi_in_t safe_query(bit aimed);
        tgi_in_t  it;
        tgi_out_t r;
        int       span, n;
        logic [31:0] t;
        begin
            span = (side_cnt < FILL_SIDE ? side_cnt : FILL_SIDE) + 1;
            for (n = 0; n < 8; n++)
            begin
                if (!aimed)
                    it = query_item(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
                else
                begin
                    if ($urandom_range(0, 3) == 0)
                        t = $urandom_range(0, 1) ? $urandom
                                                 : start_t - $urandom_range(1, 1 << 20);
                    else
                        t = aim(inv_step, longint'({32'd0, start_t}), FILL_SLICES);
                    it = query_item(2'($urandom_range(0, 9) == 0 ? 3 : $urandom_range(0, 2)),
                                    t, aim(inv_cell, -longint'({32'd0, half_w}), span),
                                    aim(inv_cell, -longint'({32'd0, half_w}), span));
                end
                if (predict_query(it, r))
                    return it;
            end
            // unknown field reads nothing
            it.field_sel = 2'd3;
            return it;
        end
    endfunction

    task automatic random_mix(int count);
        int n;
        begin
            for (n = 0; n < count; n++)
            begin
                case ($urandom_range(0, 19))
                    0: send_item(load_item(2'($urandom), 6'($urandom), 7'($urandom),
                                           7'($urandom), $urandom));
                    1, 2: send_item(load_item(2'($urandom_range(0, 2)),
                                              6'($urandom_range(0, FILL_SLICES - 1)),
                                              7'($urandom_range(0, FILL_SIDE - 1)),
                                              7'($urandom_range(0, FILL_SIDE - 1)),
                                              rand_grid_value()));
                    3, 4, 5, 6: send_item(safe_query(1'b0));
                    default: send_item(safe_query(1'b1));
                endcase
            end
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_fill_grid();
        int f, s, r, c;
        begin
            for (f = 0; f < DEF_FIELD_COUNT; f++)
                for (s = 0; s < FILL_SLICES; s++)
                    for (r = 0; r < FILL_SIDE; r++)
                        for (c = 0; c < FILL_SIDE; c++)
                            send_item(load_item(2'(f), 6'(s), 7'(r), 7'(c),
                                                rand_grid_value()));
        end
    endtask

    task automatic test_directed();
        begin
            set_config(32'h0002_0000, 32'h0001_0000, 32'd0, 32'h0001_0000, 32'h0000_8000,
                       8'd6, 7'd4);
            send_item(query_item(FLD_TEMP, 32'h0002_0000, 32'd0, 32'd0));
            send_item(query_item(FLD_VX, 32'h0003_8000, 32'h0002_4000, 32'h0001_C000));
            send_item(query_item(FLD_VY, 32'h0004_FFFF, 32'h0004_FFFF, 32'h0004_FFFF));
            // upper spatial and time edges
            send_item(query_item(FLD_TEMP, 32'h0002_0000, 32'h0005_0000, 32'd0));
            send_item(query_item(FLD_TEMP, 32'h0002_0000, 32'd0, 32'h0005_0000));
            send_item(query_item(FLD_VX, 32'h0005_0000, 32'd0, 32'd0));
            send_item(query_item(FLD_VX, 32'h7FFF_FFFF, 32'd0, 32'd0));
            // negative offset
            send_item(query_item(FLD_TEMP, 32'h0002_0000, 32'hFFFF_FFFF, 32'd0));
            send_item(query_item(FLD_TEMP, 32'h0002_0000, 32'd0, 32'h8000_0000));
            // unknown field
            send_item(query_item(2'd3, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000));
            send_item(query_item(2'd3, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000));
            // early time: positive, negative and extreme scaling
            send_item(query_item(FLD_VX, 32'h0001_0000, 32'h0001_8000, 32'h0002_0000));
            send_item(query_item(FLD_VY, 32'hFFFF_0000, 32'h0003_0000, 32'h0000_4000));
            send_item(query_item(FLD_VY, 32'h8000_0000, 32'h0000_8000, 32'h0000_8000));
            send_item(query_item(FLD_TEMP, 32'h8000_0000, 32'h0001_0000, 32'h0001_0000));
            // ignored and far loads
            send_item(load_item(2'd3, 6'd0, 7'd0, 7'd0, 32'h1234_5678));
            send_item(load_item(FLD_VY, 6'd63, 7'd127, 7'd127, 32'h8000_0000));
            send_item(load_item(FLD_TEMP, 6'd0, 7'd0, 7'd0, 32'h7FFF_FFFF));
            send_item(load_item(FLD_TEMP, 6'd0, 7'd0, 7'd1, 32'h8000_0000));
            send_item(query_item(FLD_TEMP, 32'h0002_0000, 32'h0000_8000, 32'd0));
            send_item(query_item(FLD_TEMP, 32'h0002_0000, 32'h0000_FFFF, 32'd0));
        end
    endtask

    task automatic test_register_sweep();
        begin
            set_config(32'd0, 32'h0002_0000, 32'h0003_0000, 32'h0002_0000, 32'd0, 8'd5, 7'd3);
            random_mix(140);
            set_config(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       8'd255, 7'd127);
            random_mix(80);
            set_config(32'h0001_0000, 32'h0001_0000, 32'd0, 32'h0001_0000, 32'h0001_0000,
                       8'd0, 7'd1);
            random_mix(40);
            set_config(32'h0001_0000, 32'h0001_0000, 32'd0, 32'h0001_0000, 32'h0001_0000,
                       8'd1, 7'd0);
            random_mix(30);
            set_config(32'h0001_0000, 32'h0001_8000, 32'h0000_8000, 32'h0001_0000,
                       32'h0004_0000, 8'd2, 7'd2);
            random_mix(140);
            set_config(32'h0000_6666, 32'h000A_0000, 32'h000C_CCCD, 32'h0005_0000,
                       32'h0002_8000, 8'd128, 7'd64);
            random_mix(120);
            set_config(32'h0002_0000, 32'h0001_0000, 32'd0, 32'h0001_0000, 32'h0000_8000,
                       8'd6, 7'd4);
            random_mix(160);
        end
    endtask

    task automatic test_backpressure();
        int n;
        begin
            hold_cycles = 300;
            for (n = 0; n < 40; n++)
                send_item(safe_query(1'b1));
        end
    endtask

    task automatic test_no_idle();
        begin
            drain();
            idle_on = 1'b0;
            random_mix(120);
        end
    endtask

    // ------------------------------------------------------------------
    // result sink, checker and watchdog
    // ------------------------------------------------------------------
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 2);
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        begin
            $display("%0t ns: %s mismatch, got %h want %h", $realtime, what, got, want);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        tgi_out_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
                report("unexpected transaction", out_ch.data.result_value, 32'd0);
            else
            begin
                want = pending_results.pop_front();
                if (out_ch.data.result_value !== want.result_value)
                    report("result_value", out_ch.data.result_value, want.result_value);
                if (out_ch.data.in_grid !== want.in_grid)
                    report("in_grid", 32'(out_ch.data.in_grid), 32'(want.in_grid));
                if (out_ch.data.early_time !== want.early_time)
                    report("early_time", 32'(out_ch.data.early_time), 32'(want.early_time));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("trilinear_grid_interpolator verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.data <= '0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        start_t = 32'd26214;
        inv_step = 32'd655360;
        half_w = 32'd838861;
        inv_cell = 32'd327680;
        inv_start = 32'd163840;
        side_cnt = 8'd128;
        slice_cnt = 7'd64;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_grid();
        test_directed();
        test_register_sweep();
        test_backpressure();
        test_no_idle();

        drain();
        if (mismatches == 0 && pending_results.size() == 0)
            $display("trilinear_grid_interpolator verification clean");
        else
            $display("trilinear_grid_interpolator verification failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/tgi_pkg.sv
sv/tgi_stream_if.sv
sv/tgi_ram.sv
sv/trilinear_grid_interpolator.sv
test/tb_trilinear_grid_interpolator.sv
